[rtl/core/clmt_pkg.sv]
package clmt_pkg;

   // table geometry
   localparam int SLOTS    = 16;
   localparam int GEN_BITS = 12;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);

   // handle layout: generation in the upper bits, slot plus one below
   localparam int SLOT_FIELD_BITS = 20;
   localparam int HANDLE_GEN_BITS = 12;

   // port widths fixed by the interface
   localparam int CHANNEL_W  = 32;
   localparam int HANDLE_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int LISTENER_W = 6;
   localparam int COUNT_W    = 7;

   localparam logic [CHANNEL_W-1:0] WILDCARD = 32'hFFFF_FFFF;

   // request modes
   typedef enum logic [1:0] {
      MODE_SUBSCRIBE   = 2'd0,
      MODE_UNSUBSCRIBE = 2'd1,
      MODE_PUBLISH     = 2'd2,
      MODE_CLEAR       = 2'd3
   } mode_type;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HDL = 2'd2;

   // operation broadcast to every cell
   typedef enum logic [2:0] {
      CELL_NOP,
      CELL_SUB,
      CELL_UNSUB,
      CELL_CLEAR,
      CELL_PUB_LOAD,
      CELL_PUB_STEP
   } cell_op_type;

   typedef struct packed {
      cell_op_type                op;
      logic [CHANNEL_W-1:0]       channel;
      logic                       slot_ok;
      logic [IDX_W-1:0]           slot;
      logic [HANDLE_GEN_BITS-1:0] gen;
   } cell_ctrl_type;

   typedef struct packed {
      logic                claim;
      logic                unsub_hit;
      logic                hit;
      logic                grant;
      logic [GEN_BITS-1:0] gen;
   } cell_stat_type;

endpackage

[rtl/core/clmt_cell.sv]
module clmt_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [clmt_pkg::IDX_W-1:0]   cell_index,
   input  clmt_pkg::cell_ctrl_type      ctrl,
   input  logic                         free_in,
   output logic                         free_out,
   input  logic                         pend_in,
   output logic                         pend_out,
   output clmt_pkg::cell_stat_type      stat
);

   logic                                valid_ff, valid_in;
   logic [clmt_pkg::CHANNEL_W-1:0]      channel_ff, channel_in;
   logic [clmt_pkg::GEN_BITS-1:0]       gen_ff, gen_in;
   logic                                hit_ff, hit_in;
   logic                                claim, sel, unsub_hit, grant;

   // neighbor chains: lowest free slot and lowest pending match
   assign free_out = free_in | ~valid_ff;
   assign pend_out = pend_in | hit_ff;

   always_comb begin
      claim     = (ctrl.op == clmt_pkg::CELL_SUB) & ~valid_ff & ~free_in;
      sel       = ctrl.slot_ok && (ctrl.slot == cell_index);
      unsub_hit = (ctrl.op == clmt_pkg::CELL_UNSUB) & sel & valid_ff &
                  (ctrl.gen == clmt_pkg::HANDLE_GEN_BITS'(gen_ff));
      grant     = (ctrl.op == clmt_pkg::CELL_PUB_STEP) & hit_ff & ~pend_in;

      valid_in   = valid_ff;
      channel_in = channel_ff;
      gen_in     = gen_ff;
      hit_in     = hit_ff;

      case (ctrl.op)
         clmt_pkg::CELL_SUB: begin
            if (claim) begin
               valid_in   = 1'b1;
               channel_in = ctrl.channel;
            end
         end
         clmt_pkg::CELL_UNSUB: begin
            if (unsub_hit) begin
               valid_in = 1'b0;
               gen_in   = gen_ff + clmt_pkg::GEN_BITS'(1);
            end
         end
         clmt_pkg::CELL_CLEAR: begin
            if (valid_ff) begin
               valid_in = 1'b0;
               gen_in   = gen_ff + clmt_pkg::GEN_BITS'(1);
            end
         end
         clmt_pkg::CELL_PUB_LOAD: begin
            hit_in = valid_ff & ((channel_ff == ctrl.channel) ||
                                 (channel_ff == clmt_pkg::WILDCARD));
         end
         clmt_pkg::CELL_PUB_STEP: begin
            if (grant) hit_in = 1'b0;
         end
         default: begin
         end
      endcase

      stat.claim     = claim;
      stat.unsub_hit = unsub_hit;
      stat.hit       = hit_ff;
      stat.grant     = grant;
      stat.gen       = gen_ff;
   end

   // slot state; channel needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gen_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gen_ff   <= gen_in;
         hit_ff   <= hit_in;
      end
      channel_ff <= channel_in;
   end

endmodule

[rtl/core/channel_listener_match_table_unit.sv]
// Listener table for a publish/subscribe scheme, 16 slots in a row of cells.
// Request channel: a request is taken on a clock edge with start high and
// busy low (mode, channel, handle). Subscribe claims the lowest free slot,
// unsubscribe checks slot and generation of a handle, publish lists every
// listener on the channel or on the wildcard, clear frees every slot.
// Response channel: each response shows for one cycle with rsp_valid high;
// the receiver cannot stall, so responses are never held or dropped.
// Sequencing: subscribe, unsubscribe and clear run one execute state that
// registers the response, and the next request is taken while that
// response is on the ports.
// Publish loads the compare hits in every cell in the execute state, then
// emits one match per cycle in slot order through the pending chain; busy
// stays high through the execute and publish states and falls as the last
// match, or the response for no match, is registered.
// The free-slot and pending chains ripple combinationally through the cells.
// Reset (synchronous) empties the table, zeroes all generations and the
// live count, and returns to idle; no clearing pass is needed.
module channel_listener_match_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic [clmt_pkg::CHANNEL_W-1:0]    req_channel,
   input  logic [clmt_pkg::HANDLE_W-1:0]     req_handle,
   output logic                              rsp_valid,
   output logic [clmt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [clmt_pkg::HANDLE_W-1:0]     rsp_new_handle,
   output logic                              rsp_match_valid,
   output logic [clmt_pkg::LISTENER_W-1:0]   rsp_listener_index,
   output logic [clmt_pkg::COUNT_W-1:0]      rsp_match_count,
   output logic [clmt_pkg::COUNT_W-1:0]      rsp_live_count,
   output logic                              rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PUB
   } state_type;

   state_type                               state_ff, state_in;
   clmt_pkg::mode_type                      mode_ff, mode_in;
   logic [clmt_pkg::CHANNEL_W-1:0]          channel_ff, channel_in;
   logic [clmt_pkg::HANDLE_W-1:0]           handle_ff, handle_in;
   logic [clmt_pkg::CNT_W-1:0]              live_ff, live_in;
   logic [clmt_pkg::COUNT_W-1:0]            count_ff, count_in;

   logic                                    valid_ff, valid_in;
   logic [clmt_pkg::STATUS_W-1:0]           status_ff, status_in;
   logic [clmt_pkg::HANDLE_W-1:0]           new_handle_ff, new_handle_in;
   logic                                    match_ff, match_in;
   logic [clmt_pkg::LISTENER_W-1:0]         index_ff, index_in;
   logic [clmt_pkg::COUNT_W-1:0]            mcount_ff, mcount_in;
   logic                                    last_ff, last_in;

   clmt_pkg::cell_ctrl_type                 ctrl;
   clmt_pkg::cell_stat_type                 stat [clmt_pkg::SLOTS];
   logic [clmt_pkg::SLOTS:0]                free_chain;
   logic [clmt_pkg::SLOTS:0]                pend_chain;

   logic [clmt_pkg::SLOT_FIELD_BITS-1:0]    slot_field;
   logic                                    any_claim, any_unsub, remain;
   logic [clmt_pkg::IDX_W-1:0]              claim_idx, grant_idx;
   logic [clmt_pkg::GEN_BITS-1:0]           claim_gen;

   assign busy = (state_ff != ST_IDLE);

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_new_handle     = new_handle_ff;
   assign rsp_match_valid    = match_ff;
   assign rsp_listener_index = index_ff;
   assign rsp_match_count    = mcount_ff;
   assign rsp_live_count     = clmt_pkg::COUNT_W'(live_ff);
   assign rsp_last           = last_ff;

   // handle decode and cell command
   assign slot_field = handle_ff[clmt_pkg::SLOT_FIELD_BITS-1:0];

   always_comb begin
      ctrl.channel = channel_ff;
      ctrl.slot_ok = (slot_field != '0) &&
                     (slot_field <= clmt_pkg::SLOT_FIELD_BITS'(clmt_pkg::SLOTS));
      ctrl.slot    = clmt_pkg::IDX_W'(slot_field - clmt_pkg::SLOT_FIELD_BITS'(1));
      ctrl.gen     = handle_ff[clmt_pkg::HANDLE_W-1:clmt_pkg::SLOT_FIELD_BITS];
      ctrl.op      = clmt_pkg::CELL_NOP;
      if (state_ff == ST_EXEC) begin
         case (mode_ff)
            clmt_pkg::MODE_SUBSCRIBE:   ctrl.op = clmt_pkg::CELL_SUB;
            clmt_pkg::MODE_UNSUBSCRIBE: ctrl.op = clmt_pkg::CELL_UNSUB;
            clmt_pkg::MODE_PUBLISH:     ctrl.op = clmt_pkg::CELL_PUB_LOAD;
            clmt_pkg::MODE_CLEAR:       ctrl.op = clmt_pkg::CELL_CLEAR;
            default:                    ctrl.op = clmt_pkg::CELL_NOP;
         endcase
      end else if (state_ff == ST_PUB) begin
         ctrl.op = clmt_pkg::CELL_PUB_STEP;
      end
   end

   // row of slot cells
   assign free_chain[0] = 1'b0;
   assign pend_chain[0] = 1'b0;

   for (genvar g = 0; g < clmt_pkg::SLOTS; g++) begin : g_cell
      clmt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (clmt_pkg::IDX_W'(g)),
         .ctrl       (ctrl),
         .free_in    (free_chain[g]),
         .free_out   (free_chain[g+1]),
         .pend_in    (pend_chain[g]),
         .pend_out   (pend_chain[g+1]),
         .stat       (stat[g])
      );
   end

   // gather one-hot cell status
   always_comb begin
      any_claim = 1'b0;
      any_unsub = 1'b0;
      remain    = 1'b0;
      claim_idx = '0;
      grant_idx = '0;
      claim_gen = '0;
      for (int i = 0; i < clmt_pkg::SLOTS; i++) begin
         any_claim = any_claim | stat[i].claim;
         any_unsub = any_unsub | stat[i].unsub_hit;
         remain    = remain | (stat[i].hit & ~stat[i].grant);
         if (stat[i].claim) begin
            claim_idx = claim_idx | clmt_pkg::IDX_W'(i);
            claim_gen = claim_gen | stat[i].gen;
         end
         if (stat[i].grant) grant_idx = grant_idx | clmt_pkg::IDX_W'(i);
      end
   end

   // sequencer and response registers
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      channel_in    = channel_ff;
      handle_in     = handle_ff;
      live_in       = live_ff;
      count_in      = count_ff;
      valid_in      = 1'b0;
      status_in     = clmt_pkg::STATUS_OK;
      new_handle_in = '0;
      match_in      = 1'b0;
      index_in      = '0;
      mcount_in     = '0;
      last_in       = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in    = clmt_pkg::mode_type'(req_mode);
               channel_in = req_channel;
               handle_in  = req_handle;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (mode_ff)
               clmt_pkg::MODE_SUBSCRIBE: begin
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
                  if (any_claim) begin
                     live_in       = live_ff + clmt_pkg::CNT_W'(1);
                     new_handle_in = {clmt_pkg::HANDLE_GEN_BITS'(claim_gen),
                                      clmt_pkg::SLOT_FIELD_BITS'(claim_idx) +
                                      clmt_pkg::SLOT_FIELD_BITS'(1)};
                  end else begin
                     status_in = clmt_pkg::STATUS_FULL;
                  end
               end
               clmt_pkg::MODE_UNSUBSCRIBE: begin
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
                  if (any_unsub) begin
                     if (live_ff != '0) live_in = live_ff - clmt_pkg::CNT_W'(1);
                  end else begin
                     status_in = clmt_pkg::STATUS_BAD_HDL;
                  end
               end
               clmt_pkg::MODE_PUBLISH: begin
                  count_in = '0;
                  state_in = ST_PUB;
               end
               clmt_pkg::MODE_CLEAR: begin
                  valid_in = 1'b1;
                  live_in  = '0;
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PUB: begin
            valid_in = 1'b1;
            if (pend_chain[clmt_pkg::SLOTS]) begin
               match_in  = 1'b1;
               index_in  = clmt_pkg::LISTENER_W'(grant_idx);
               mcount_in = count_ff + clmt_pkg::COUNT_W'(1);
               count_in  = count_ff + clmt_pkg::COUNT_W'(1);
               last_in   = ~remain;
               if (!remain) state_in = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         valid_ff <= valid_in;
      end
      mode_ff       <= mode_in;
      channel_ff    <= channel_in;
      handle_ff     <= handle_in;
      count_ff      <= count_in;
      status_ff     <= status_in;
      new_handle_ff <= new_handle_in;
      match_ff      <= match_in;
      index_ff      <= index_in;
      mcount_ff     <= mcount_in;
      last_ff       <= last_in;
   end

endmodule
